### hw/rtl/flt_pkg.sv
package flt_pkg;

  // op codes of the command channel
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_WATER = 3'd1,
    OP_LOAD  = 3'd2,
    OP_SET   = 3'd3,
    OP_CLEAR = 3'd4,
    OP_READ  = 3'd5
  } op_e;

  // filter status codes
  typedef enum logic [1:0] {
    STAT_NEW     = 2'd0,
    STAT_NORMAL  = 2'd1,
    STAT_WARNING = 2'd2,
    STAT_EXPIRED = 2'd3
  } status_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_TEST_ACTIVE    = 3'd0,
    REG_FAST_ENABLE    = 3'd1,
    REG_WARN_SEC       = 3'd2,
    REG_WARN_ML        = 3'd3,
    REG_FAST_SEC       = 3'd4,
    REG_FAST_SEC_WARN  = 3'd5,
    REG_FAST_ML        = 3'd6,
    REG_FAST_ML_WARN   = 3'd7
  } cfg_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DED_SEC,
    S_DED_ML,
    S_CLS_SEC,
    S_CLS_ML,
    S_EMIT
  } state_e;

  localparam int unsigned DataW = 32;
  localparam int unsigned StepW = 16;

  // control group from sequencer to datapath
  typedef struct packed {
    logic load_wr;
    logic set_wr;
    logic clr_cnt;
    logic tick_cnt;
    logic mul;
    logic ded_sec;
    logic ded_ml;
    logic cls_sec;
    logic cls_ml;
    logic emit;
    logic last;
  } ctl_t;

endpackage

### hw/rtl/flt_alu.sv
module flt_alu (
  input  logic [flt_pkg::DataW-1:0] val_i,
  input  logic [flt_pkg::DataW-1:0] step_i,
  input  logic [flt_pkg::DataW-1:0] thr_i,
  input  logic                      clamp_i,
  output logic [flt_pkg::DataW-1:0] res_o,
  output logic                      le_thr_o,
  output logic                      zero_o
);
  import flt_pkg::*;

  logic [DataW-1:0] diff;
  logic             gt;

  // shared subtract and compare
  assign diff = val_i - step_i;
  assign gt   = val_i > step_i;

  // deduct with floor at zero, or stop at the threshold
  always_comb begin
    if (clamp_i && gt && (diff < thr_i)) begin
      res_o = thr_i;
    end else if (gt) begin
      res_o = diff;
    end else begin
      res_o = '0;
    end
  end

  // classification flags
  assign le_thr_o = val_i <= thr_i;
  assign zero_o   = val_i == '0;

endmodule

### hw/rtl/flt_ctrl.sv
module flt_ctrl #(
  parameter int unsigned NUM_FILTERS = 4,
  parameter int unsigned IdxW = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2:0]      op_i,
  input  logic [3:0]      filter_index_i,
  output logic            busy_o,
  output logic [IdxW-1:0] idx_o,
  output flt_pkg::ctl_t   ctl_o
);
  import flt_pkg::*;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            accept;
  logic            in_range;
  logic            last_flt;
  op_e             op;

  assign op       = op_e'(op_i);
  assign accept   = start_i && (state_q == S_IDLE);
  assign in_range = {1'b0, filter_index_i} < 5'(NUM_FILTERS);
  assign last_flt = idx_q == IdxW'(NUM_FILTERS - 1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (op)
            OP_TICK:  state_d = S_DED_SEC;
            OP_WATER: state_d = in_range ? S_MUL : S_IDLE;
            OP_LOAD,
            OP_SET,
            OP_READ:  state_d = in_range ? S_EMIT : S_IDLE;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_MUL:     state_d = S_DED_ML;
      S_DED_ML:  state_d = S_EMIT;
      S_EMIT:    state_d = S_IDLE;
      S_DED_SEC: state_d = S_CLS_SEC;
      S_CLS_SEC: state_d = S_CLS_ML;
      S_CLS_ML:  state_d = last_flt ? S_IDLE : S_DED_SEC;
      default:   state_d = S_IDLE;
    endcase
  end

  // filter pointer
  always_comb begin
    idx_d = idx_q;
    if (accept) begin
      idx_d = (op == OP_TICK) ? '0 : filter_index_i[IdxW-1:0];
    end else if ((state_q == S_CLS_ML) && !last_flt) begin
      idx_d = idx_q + 1'b1;
    end
  end

  // control outputs
  always_comb begin
    ctl_o          = '0;
    ctl_o.load_wr  = accept && (op == OP_LOAD) && in_range;
    ctl_o.set_wr   = accept && (op == OP_SET) && in_range;
    ctl_o.clr_cnt  = accept && (op == OP_CLEAR);
    ctl_o.tick_cnt = accept && (op == OP_TICK);
    ctl_o.mul      = state_q == S_MUL;
    ctl_o.ded_sec  = state_q == S_DED_SEC;
    ctl_o.ded_ml   = state_q == S_DED_ML;
    ctl_o.cls_sec  = state_q == S_CLS_SEC;
    ctl_o.cls_ml   = state_q == S_CLS_ML;
    ctl_o.emit     = (state_q == S_CLS_ML) || (state_q == S_EMIT);
    ctl_o.last     = (state_q == S_EMIT) || ((state_q == S_CLS_ML) && last_flt);
  end

  assign busy_o = state_q != S_IDLE;
  assign idx_o  = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

### hw/rtl/filter_life_tracker_unit.sv
// filter life tracker: remaining seconds and millilitres for a set of filters
//
// command channel: an op is taken at a clock edge where start_i is high and
// busy_o is low; the op fields are sampled at that edge. busy_o stays high
// while the op is worked on.
// result channel: each result beat is on the out_* ports for one cycle with
// out_valid_o high; last_o marks the final beat of an op. there is no
// back-pressure, the receiver must take every beat.
// sequencing: a tick walks the filters one after another through one shared
// subtract/compare unit, in the states deduct, seconds compare and millilitre
// compare for each filter, stays busy until the last filter is done and gives
// one beat per filter. a water op goes through a multiply, a deduct and a
// report state in that order, then shows its beat. load, set status and read
// go through the report state alone before their beat. clear gives no beat
// and a new op may follow in the next cycle.
// configuration: cfg_we_i writes register cfg_idx_i at once; write only while
// busy_o is low and no beat is pending.
// reset: all stores clear to zero, status to factory new, the test counter to
// zero and the registers to their defaults; no clearing pass is needed.
module filter_life_tracker_unit #(
  parameter int unsigned NUM_FILTERS = 4,
  parameter int unsigned MIX_MODE    = 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  op_i,
  input  logic [3:0]  filter_index_i,
  input  logic [15:0] amount_ml_i,
  input  logic [31:0] load_total_ml_i,
  input  logic [31:0] load_total_sec_i,
  input  logic [31:0] load_remain_ml_i,
  input  logic [31:0] load_remain_sec_i,
  input  logic [1:0]  new_status_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        out_valid_o,
  output logic [3:0]  out_index_o,
  output logic [31:0] out_remain_sec_o,
  output logic [31:0] out_remain_ml_o,
  output logic [31:0] out_total_sec_o,
  output logic [31:0] out_total_ml_o,
  output logic [1:0]  out_status_o,
  output logic [31:0] test_seconds_o,
  output logic        last_o
);
  import flt_pkg::*;

  localparam int unsigned IdxW = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;

  // configuration registers
  logic             test_active_q;
  logic             fast_enable_q;
  logic [DataW-1:0] warn_sec_q;
  logic [DataW-1:0] warn_ml_q;
  logic [StepW-1:0] fast_sec_q;
  logic [StepW-1:0] fast_sec_warn_q;
  logic [StepW-1:0] fast_ml_q;
  logic [StepW-1:0] fast_ml_warn_q;

  // filter stores
  logic [DataW-1:0] rsec_q [NUM_FILTERS];
  logic [DataW-1:0] rml_q  [NUM_FILTERS];
  logic [DataW-1:0] tsec_q [NUM_FILTERS];
  logic [DataW-1:0] tml_q  [NUM_FILTERS];
  status_e          stat_q [NUM_FILTERS];
  logic [DataW-1:0] cnt_q;

  // working registers
  logic [StepW-1:0] amount_q;
  logic [DataW-1:0] prod_q;
  logic             sec_zero_q;
  logic             sec_le_q;

  // result registers
  logic             valid_q;
  logic [3:0]       o_index_q;
  logic [DataW-1:0] o_rsec_q;
  logic [DataW-1:0] o_rml_q;
  logic [DataW-1:0] o_tsec_q;
  logic [DataW-1:0] o_tml_q;
  status_e          o_stat_q;
  logic [DataW-1:0] o_cnt_q;
  logic             o_last_q;

  ctl_t             ctl;
  logic [IdxW-1:0]  cur;
  status_e          cur_stat;
  status_e          new_stat;
  logic             fast;
  logic [StepW-1:0] sec_step;
  logic [StepW-1:0] ml_step;
  logic [DataW-1:0] alu_val;
  logic [DataW-1:0] alu_step;
  logic [DataW-1:0] alu_thr;
  logic             alu_clamp;
  logic [DataW-1:0] alu_res;
  logic             alu_le;
  logic             alu_zero;

  // sequencer
  flt_ctrl #(
    .NUM_FILTERS (NUM_FILTERS),
    .IdxW        (IdxW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .op_i           (op_i),
    .filter_index_i (filter_index_i),
    .busy_o         (busy_o),
    .idx_o          (cur),
    .ctl_o          (ctl)
  );

  assign cur_stat = stat_q[cur];
  assign fast     = test_active_q && fast_enable_q;

  // step selection
  always_comb begin
    sec_step = StepW'(1);
    ml_step  = StepW'(1);
    if (fast) begin
      if ((MIX_MODE != 0) && (cur_stat == STAT_WARNING)) begin
        sec_step = fast_sec_warn_q;
        ml_step  = fast_ml_warn_q;
      end else begin
        sec_step = fast_sec_q;
        ml_step  = fast_ml_q;
      end
    end
  end

  // operand selection for the shared unit
  always_comb begin
    if (ctl.ded_ml || ctl.cls_ml) begin
      alu_val = rml_q[cur];
      alu_thr = warn_ml_q;
    end else begin
      alu_val = rsec_q[cur];
      alu_thr = warn_sec_q;
    end
    if (ctl.ded_ml) begin
      alu_step = prod_q;
    end else begin
      alu_step = {{(DataW-StepW){1'b0}}, sec_step};
    end
  end

  assign alu_clamp = (MIX_MODE != 0) && test_active_q && (cur_stat == STAT_NORMAL);

  flt_alu u_alu (
    .val_i    (alu_val),
    .step_i   (alu_step),
    .thr_i    (alu_thr),
    .clamp_i  (alu_clamp),
    .res_o    (alu_res),
    .le_thr_o (alu_le),
    .zero_o   (alu_zero)
  );

  // reclassification
  always_comb begin
    if ((cur_stat == STAT_NEW) && !test_active_q) begin
      new_stat = cur_stat;
    end else if (sec_zero_q || alu_zero) begin
      new_stat = STAT_EXPIRED;
    end else if (sec_le_q || alu_le) begin
      new_stat = STAT_WARNING;
    end else begin
      new_stat = STAT_NORMAL;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      test_active_q   <= 1'b0;
      fast_enable_q   <= 1'b0;
      warn_sec_q      <= '0;
      warn_ml_q       <= '0;
      fast_sec_q      <= StepW'(1);
      fast_sec_warn_q <= StepW'(1);
      fast_ml_q       <= StepW'(1);
      fast_ml_warn_q  <= StepW'(1);
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        REG_TEST_ACTIVE:   test_active_q   <= cfg_wdata_i[0];
        REG_FAST_ENABLE:   fast_enable_q   <= cfg_wdata_i[0];
        REG_WARN_SEC:      warn_sec_q      <= cfg_wdata_i;
        REG_WARN_ML:       warn_ml_q       <= cfg_wdata_i;
        REG_FAST_SEC:      fast_sec_q      <= cfg_wdata_i[StepW-1:0];
        REG_FAST_SEC_WARN: fast_sec_warn_q <= cfg_wdata_i[StepW-1:0];
        REG_FAST_ML:       fast_ml_q       <= cfg_wdata_i[StepW-1:0];
        REG_FAST_ML_WARN:  fast_ml_warn_q  <= cfg_wdata_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  // filter store updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_FILTERS; i++) begin
        rsec_q[i] <= '0;
        rml_q[i]  <= '0;
        tsec_q[i] <= '0;
        tml_q[i]  <= '0;
        stat_q[i] <= STAT_NEW;
      end
    end else begin
      for (int i = 0; i < NUM_FILTERS; i++) begin
        if (ctl.load_wr && (filter_index_i == 4'(i))) begin
          tml_q[i]  <= load_total_ml_i;
          tsec_q[i] <= load_total_sec_i;
          rml_q[i]  <= load_remain_ml_i;
          rsec_q[i] <= load_remain_sec_i;
          stat_q[i] <= status_e'(new_status_i);
        end
        if (ctl.set_wr && (filter_index_i == 4'(i))) begin
          stat_q[i] <= status_e'(new_status_i);
        end
        if (ctl.ded_sec && (cur == IdxW'(i))) begin
          rsec_q[i] <= alu_res;
        end
        if (ctl.ded_ml && (cur == IdxW'(i))) begin
          rml_q[i] <= alu_res;
        end
        if (ctl.cls_ml && (cur == IdxW'(i))) begin
          stat_q[i] <= new_stat;
        end
      end
    end
  end

  // saturating test counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctl.clr_cnt) begin
      cnt_q <= '0;
    end else if (ctl.tick_cnt && test_active_q && (cnt_q != '1)) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // volume product and seconds flags
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      amount_q <= amount_ml_i;
    end
    if (ctl.mul) begin
      prod_q <= DataW'(ml_step) * DataW'(amount_q);
    end
    if (ctl.cls_sec) begin
      sec_zero_q <= alu_zero;
      sec_le_q   <= alu_le;
    end
  end

  // result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.emit) begin
      o_index_q <= 4'(cur);
      o_rsec_q  <= rsec_q[cur];
      o_rml_q   <= rml_q[cur];
      o_tsec_q  <= tsec_q[cur];
      o_tml_q   <= tml_q[cur];
      o_stat_q  <= ctl.cls_ml ? new_stat : cur_stat;
      o_cnt_q   <= cnt_q;
      o_last_q  <= ctl.last;
    end
  end

  assign out_valid_o      = valid_q;
  assign out_index_o      = o_index_q;
  assign out_remain_sec_o = o_rsec_q;
  assign out_remain_ml_o  = o_rml_q;
  assign out_total_sec_o  = o_tsec_q;
  assign out_total_ml_o   = o_tml_q;
  assign out_status_o     = o_stat_q;
  assign test_seconds_o   = o_cnt_q;
  assign last_o           = o_last_q;

`ifndef SYNTHESIS
  // a beat only follows a cycle of work
  a_beat_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(busy_o))
    else $error("result beat without preceding work");

  // the final beat of an op coincides with the block being free again
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> !busy_o)
    else $error("busy after final beat");

  // a beat that is not final leaves the block busy
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> busy_o)
    else $error("idle before final beat");

  // clear op zeroes the counter
  a_clear_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.clr_cnt |=> (cnt_q == '0))
    else $error("test counter not cleared");
`endif

endmodule

### bench/filter_life_tracker_unit_tb.sv
module filter_life_tracker_unit_tb;
  import flt_pkg::*;

  localparam int unsigned NUM_FILTERS = 4;
  localparam int unsigned MIX_MODE    = 1;
  localparam int unsigned DRAIN_CYC   = 16;
  localparam int unsigned TIMEOUT     = 3000000;

  // op codes the block treats as no-ops
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  // one command as driven on the op channel
  typedef struct {
    logic [2:0]  op;
    logic [3:0]  idx;
    logic [15:0] amount;
    logic [31:0] tml;
    logic [31:0] tsec;
    logic [31:0] rml;
    logic [31:0] rsec;
    logic [1:0]  nst;
  } cmd_t;

  // one filter report beat
  typedef struct {
    logic [3:0]  idx;
    logic [31:0] rsec;
    logic [31:0] rml;
    logic [31:0] tsec;
    logic [31:0] tml;
    status_e     stat;
    logic [31:0] cnt;
    logic        last;
  } report_t;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        start_i           = 1'b0;
  logic [2:0]  op_i              = '0;
  logic [3:0]  filter_index_i    = '0;
  logic [15:0] amount_ml_i       = '0;
  logic [31:0] load_total_ml_i   = '0;
  logic [31:0] load_total_sec_i  = '0;
  logic [31:0] load_remain_ml_i  = '0;
  logic [31:0] load_remain_sec_i = '0;
  logic [1:0]  new_status_i      = '0;
  logic        cfg_we_i          = 1'b0;
  logic [2:0]  cfg_idx_i         = '0;
  logic [31:0] cfg_wdata_i       = '0;
  logic        busy_o;
  logic        out_valid_o;
  logic [3:0]  out_index_o;
  logic [31:0] out_remain_sec_o;
  logic [31:0] out_remain_ml_o;
  logic [31:0] out_total_sec_o;
  logic [31:0] out_total_ml_o;
  logic [1:0]  out_status_o;
  logic [31:0] test_seconds_o;
  logic        last_o;

  // shadow copy of the filter stores and the counter
  logic [31:0] life_sec   [NUM_FILTERS];
  logic [31:0] life_ml    [NUM_FILTERS];
  logic [31:0] design_sec [NUM_FILTERS];
  logic [31:0] design_ml  [NUM_FILTERS];
  status_e     filt_stat  [NUM_FILTERS];
  logic [31:0] test_cnt   = '0;

  // shadow copy of the registers
  logic        r_test      = 1'b0;
  logic        r_fast      = 1'b0;
  logic [31:0] r_warn_sec  = '0;
  logic [31:0] r_warn_ml   = '0;
  logic [15:0] r_sec_step  = 16'd1;
  logic [15:0] r_sec_stepw = 16'd1;
  logic [15:0] r_ml_step   = 16'd1;
  logic [15:0] r_ml_stepw  = 16'd1;

  cmd_t        cmd_q [$];
  report_t     report_q [$];
  cmd_t        cur_cmd;
  int unsigned gap_pct   = 0;
  int unsigned sent_cnt  = 0;
  int unsigned taken_cnt = 0;
  int unsigned err_cnt   = 0;

  filter_life_tracker_unit #(
    .NUM_FILTERS(NUM_FILTERS),
    .MIX_MODE   (MIX_MODE)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .op_i             (op_i),
    .filter_index_i   (filter_index_i),
    .amount_ml_i      (amount_ml_i),
    .load_total_ml_i  (load_total_ml_i),
    .load_total_sec_i (load_total_sec_i),
    .load_remain_ml_i (load_remain_ml_i),
    .load_remain_sec_i(load_remain_sec_i),
    .new_status_i     (new_status_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_valid_o      (out_valid_o),
    .out_index_o      (out_index_o),
    .out_remain_sec_o (out_remain_sec_o),
    .out_remain_ml_o  (out_remain_ml_o),
    .out_total_sec_o  (out_total_sec_o),
    .out_total_ml_o   (out_total_ml_o),
    .out_status_o     (out_status_o),
    .test_seconds_o   (test_seconds_o),
    .last_o           (last_o)
  );

  always #5 clk_i = ~clk_i;

  // step size for the current mode and status
  function automatic logic [31:0] step_for(status_e st, logic [15:0] step_n,
                                           logic [15:0] step_w);
    if (!r_test || !r_fast) return 32'd1;
    if (MIX_MODE != 0 && st == STAT_WARNING) return {16'h0, step_w};
    return {16'h0, step_n};
  endfunction

  // subtract with floor at zero; normal filters in test mode stop at the threshold
  function automatic logic [31:0] deduct(logic [31:0] val, status_e st, logic [31:0] step,
                                         logic [31:0] thr);
    if (MIX_MODE != 0 && r_test && st == STAT_NORMAL && val > step && val - step < thr)
      return thr;
    return (val > step) ? val - step : '0;
  endfunction

  // status from remaining life; factory new filters stay put outside test mode
  function automatic void grade_filter(int unsigned i);
    if (filt_stat[i] == STAT_NEW && !r_test) return;
    if (life_sec[i] == 0 || life_ml[i] == 0) filt_stat[i] = STAT_EXPIRED;
    else if (life_sec[i] <= r_warn_sec || life_ml[i] <= r_warn_ml) filt_stat[i] = STAT_WARNING;
    else filt_stat[i] = STAT_NORMAL;
  endfunction

  function automatic void queue_report(int unsigned i, logic last);
    report_t r;
    r.idx  = 4'(i);
    r.rsec = life_sec[i];
    r.rml  = life_ml[i];
    r.tsec = design_sec[i];
    r.tml  = design_ml[i];
    r.stat = filt_stat[i];
    r.cnt  = test_cnt;
    r.last = last;
    report_q.push_back(r);
  endfunction

  // update the filter stores for one accepted op and queue its report beats
  function automatic void track_life(cmd_t c);
    logic [31:0] step;
    if (c.op == OP_TICK) begin
      for (int unsigned i = 0; i < NUM_FILTERS; i++) begin
        step = step_for(filt_stat[i], r_sec_step, r_sec_stepw);
        life_sec[i] = deduct(life_sec[i], filt_stat[i], step, r_warn_sec);
        grade_filter(i);
      end
      if (r_test && test_cnt != '1) test_cnt = test_cnt + 1;
      for (int unsigned i = 0; i < NUM_FILTERS; i++) queue_report(i, i + 1 == NUM_FILTERS);
      return;
    end
    if (c.op == OP_CLEAR) begin
      test_cnt = '0;
      return;
    end
    if (c.op > OP_READ || c.idx >= NUM_FILTERS) return;
    case (c.op)
      OP_WATER: begin
        step = step_for(filt_stat[c.idx], r_ml_step, r_ml_stepw);
        life_ml[c.idx] = deduct(life_ml[c.idx], filt_stat[c.idx], step * {16'h0, c.amount},
                                r_warn_ml);
      end
      OP_LOAD: begin
        design_ml[c.idx]  = c.tml;
        design_sec[c.idx] = c.tsec;
        life_ml[c.idx]    = c.rml;
        life_sec[c.idx]   = c.rsec;
        filt_stat[c.idx]  = status_e'(c.nst);
      end
      OP_SET: filt_stat[c.idx] = status_e'(c.nst);
      default: ;
    endcase
    queue_report(c.idx, 1'b1);
  endfunction

  // driver: note the op taken at the edge, then present the next op at the falling edge
  always @(posedge clk_i) begin : drive_cmds
    logic took;
    took = rst_ni && start_i && !busy_o;
    if (took) begin
      track_life(cur_cmd);
      taken_cnt++;
    end
    @(negedge clk_i);
    if (took || !start_i) begin
      if (cmd_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
        cur_cmd = cmd_q.pop_front();
        op_i              <= cur_cmd.op;
        filter_index_i    <= cur_cmd.idx;
        amount_ml_i       <= cur_cmd.amount;
        load_total_ml_i   <= cur_cmd.tml;
        load_total_sec_i  <= cur_cmd.tsec;
        load_remain_ml_i  <= cur_cmd.rml;
        load_remain_sec_i <= cur_cmd.rsec;
        new_status_i      <= cur_cmd.nst;
        start_i           <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // monitor: every result beat against the oldest queued report
  always @(posedge clk_i) begin : watch_reports
    report_t r;
    if (rst_ni && out_valid_o) begin
      if (report_q.size() == 0) begin
        $error("result beat for filter %0d with no report queued", out_index_o);
        err_cnt++;
      end else begin
        r = report_q.pop_front();
        check_field("out_index", r.idx, out_index_o);
        check_field("out_remain_sec", r.rsec, out_remain_sec_o);
        check_field("out_remain_ml", r.rml, out_remain_ml_o);
        check_field("out_total_sec", r.tsec, out_total_sec_o);
        check_field("out_total_ml", r.tml, out_total_ml_o);
        check_field("out_status", r.stat, out_status_o);
        check_field("test_seconds", r.cnt, test_seconds_o);
        check_field("last", r.last, last_o);
      end
    end
  end

  function automatic cmd_t mk(logic [2:0] op, logic [3:0] idx, logic [15:0] amount,
                              logic [31:0] tml, logic [31:0] tsec, logic [31:0] rml,
                              logic [31:0] rsec, logic [1:0] nst);
    cmd_t c;
    c.op = op; c.idx = idx; c.amount = amount;
    c.tml = tml; c.tsec = tsec; c.rml = rml; c.rsec = rsec; c.nst = nst;
    return c;
  endfunction

  task automatic send(cmd_t c);
    cmd_q.push_back(c);
    sent_cnt++;
  endtask

  // remaining life mostly around the threshold so warning and expiry are reached
  function automatic logic [31:0] near_thr(logic [31:0] thr, int unsigned spread);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return $urandom;
    return thr + $urandom_range(0, 2 * spread) - spread;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 34) c.op = OP_TICK;
    else if (r < 58) c.op = OP_WATER;
    else if (r < 74) c.op = OP_LOAD;
    else if (r < 81) c.op = OP_SET;
    else if (r < 89) c.op = OP_READ;
    else if (r < 93) c.op = OP_CLEAR;
    else c.op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_B));
    if ($urandom_range(0, 9) == 0) c.idx = 4'($urandom_range(NUM_FILTERS, 15));
    else c.idx = 4'($urandom_range(0, NUM_FILTERS - 1));
    if ($urandom_range(0, 5) == 0) c.amount = 16'($urandom_range(0, 65535));
    else c.amount = 16'($urandom_range(0, 40));
    c.tml  = $urandom;
    c.tsec = $urandom;
    c.rml  = near_thr(r_warn_ml, 100);
    c.rsec = near_thr(r_warn_sec, 12);
    c.nst  = 2'($urandom_range(0, 3));
    return c;
  endfunction

  // register write at the falling edge, shadow copy updated alongside
  task automatic write_reg(cfg_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_TEST_ACTIVE:   r_test      = val[0];
      REG_FAST_ENABLE:   r_fast      = val[0];
      REG_WARN_SEC:      r_warn_sec  = val;
      REG_WARN_ML:       r_warn_ml   = val;
      REG_FAST_SEC:      r_sec_step  = val[15:0];
      REG_FAST_SEC_WARN: r_sec_stepw = val[15:0];
      REG_FAST_ML:       r_ml_step   = val[15:0];
      REG_FAST_ML_WARN:  r_ml_stepw  = val[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(logic ta, logic fe, logic [31:0] wsec, logic [31:0] wml,
                          logic [15:0] ssec, logic [15:0] ssecw, logic [15:0] sml,
                          logic [15:0] smlw);
    write_reg(REG_TEST_ACTIVE, {31'h0, ta});
    write_reg(REG_FAST_ENABLE, {31'h0, fe});
    write_reg(REG_WARN_SEC, wsec);
    write_reg(REG_WARN_ML, wml);
    write_reg(REG_FAST_SEC, {16'h0, ssec});
    write_reg(REG_FAST_SEC_WARN, {16'h0, ssecw});
    write_reg(REG_FAST_ML, {16'h0, sml});
    write_reg(REG_FAST_ML_WARN, {16'h0, smlw});
  endtask

  // hold off until every op is taken and every report beat has come, then let it settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (taken_cnt != sent_cnt || busy_o || report_q.size() != 0);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  task automatic run_random(int unsigned n);
    for (int unsigned k = 0; k < n; k++) send(rand_cmd());
    wait_idle();
  endtask

  initial begin : stimulus
    for (int unsigned i = 0; i < NUM_FILTERS; i++) begin
      life_sec[i]   = '0;
      life_ml[i]    = '0;
      design_sec[i] = '0;
      design_ml[i]  = '0;
      filt_stat[i]  = STAT_NEW;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed ops with reset settings
    gap_pct = 24;
    send(mk(OP_READ, 4'd0, '0, '0, '0, '0, '0, STAT_NEW));
    send(mk(OP_TICK, 4'd0, '0, '0, '0, '0, '0, STAT_NEW));
    send(mk(OP_LOAD, 4'd0, '1, '1, '1, '1, '1, STAT_EXPIRED));
    send(mk(OP_LOAD, 4'd1, '0, '0, '0, '0, '0, STAT_NEW));
    send(mk(OP_LOAD, 4'd2, '0, 32'd1000, 32'd500, 32'd300, 32'd2, STAT_NORMAL));
    send(mk(OP_LOAD, 4'd3, '0, 32'd10, 32'd10, 32'd1, 32'd1, STAT_WARNING));
    send(mk(OP_TICK, 4'd0, '0, '0, '0, '0, '0, STAT_NEW));
    send(mk(OP_TICK, 4'd0, '0, '0, '0, '0, '0, STAT_NEW));
    send(mk(OP_WATER, 4'd0, '1, '0, '0, '0, '0, STAT_NEW));
    send(mk(OP_WATER, 4'd1, '0, '0, '0, '0, '0, STAT_NEW));
    send(mk(OP_WATER, 4'd2, 16'd500, '0, '0, '0, '0, STAT_NEW));
    send(mk(OP_SET, 4'd1, '0, '0, '0, '0, '0, STAT_WARNING));
    send(mk(OP_SET, 4'd3, '0, '0, '0, '0, '0, STAT_NORMAL));
    // filter index out of range
    send(mk(OP_READ, 4'd15, '1, '1, '1, '1, '1, STAT_EXPIRED));
    send(mk(OP_WATER, 4'(NUM_FILTERS), 16'd7, '0, '0, '0, '0, STAT_NEW));
    send(mk(OP_LOAD, 4'd8, '0, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
            STAT_NORMAL));
    send(mk(OP_SET, 4'd12, '0, '0, '0, '0, '0, STAT_EXPIRED));
    send(mk(OP_CLEAR, 4'd0, '0, '0, '0, '0, '0, STAT_NEW));
    // unused op codes
    send(mk(OP_SPARE_A, 4'd0, '1, '1, '1, '1, '1, STAT_EXPIRED));
    send(mk(OP_SPARE_B, 4'd2, '0, '0, '0, '0, '0, STAT_NEW));
    send(mk(OP_READ, 4'd3, '0, '0, '0, '0, '0, STAT_NEW));
    send(mk(OP_TICK, 4'd0, '0, '0, '0, '0, '0, STAT_NEW));
    send(mk(OP_READ, 4'd1, '0, '0, '0, '0, '0, STAT_NEW));
    wait_idle();
    run_random(72);

    // test mode, slow steps
    set_regs(1'b1, 1'b0, 32'd10, 32'd100, 16'd3, 16'd2, 16'd5, 16'd7);
    run_random(72);

    // fast test steps, sender idles often
    gap_pct = 67;
    set_regs(1'b1, 1'b1, 32'd20, 32'd300, 16'd3, 16'd1, 16'd4, 16'd2);
    run_random(72);

    // test mode off with top thresholds and top steps
    set_regs(1'b0, 1'b1, '1, '1, '1, '1, '1, '1);
    run_random(72);

    // zero thresholds, zero normal steps and unit warning steps, no idling from here on
    gap_pct = 0;
    set_regs(1'b1, 1'b1, '0, '0, 16'd0, 16'd1, 16'd0, 16'd1);
    run_random(72);

    // large steps against a normal filter's threshold clamp
    set_regs(1'b1, 1'b1, 32'd50, 32'd2000, '1, 16'd1, 16'd1, '1);
    run_random(72);

    if (err_cnt == 0) begin
      $display("filter_life_tracker_unit_tb OK");
    end else begin
      $display("filter_life_tracker_unit_tb NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #(TIMEOUT);
    $display("filter_life_tracker_unit_tb NOT OK");
    $finish;
  end

endmodule

### sim.f
hw/rtl/flt_pkg.sv
hw/rtl/flt_alu.sv
hw/rtl/flt_ctrl.sv
hw/rtl/filter_life_tracker_unit.sv
bench/filter_life_tracker_unit_tb.sv
